// ===== hw/rtl/sla_pkg.sv =====
// Shared constants, codes and control structs for the serial line assembler.
// No dependencies; imported by sla_ctrl, sla_datapath and serial_line_assembler.
package sla_pkg;

    localparam int LINE_MAX    = 64;
    localparam int STORE_DEPTH = LINE_MAX - 1;
    localparam int LEN_W       = $clog2(LINE_MAX);
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_EN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ERR_EN  = 1'd1;

    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_NUL = 8'd0;

    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_EMPTY    = 2'd1;
    localparam logic [1:0] KIND_TOO_LONG = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } sla_state_t;

    // controller -> datapath
    typedef struct packed {
        logic store_byte;
        logic clear_len;
        logic set_cr;
        logic clear_cr;
        logic load_empty;
        logic load_error;
        logic load_byte;
        logic start_read;
        logic advance;
    } sla_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_lf;
        logic is_cr;
        logic cr_seen;
        logic len_zero;
        logic len_full;
        logic last_idx;
        logic out_free;
        logic line_en;
        logic err_en;
    } sla_status_t;

endpackage

// ===== hw/rtl/serial_line_assembler.sv =====
// Serial line assembler: CR/LF line framer, one received byte per input word.
// An empty-line or error result is loaded into the output register when the byte is
// taken; a stored line is read out of the line store into rd_data_reg, then into the output
// register, one byte per cycle while the output is free (one read port, registered read).
// Throughput: one byte per cycle while the output is free; s_ready stays low while a line streams out.
// Reset (aresetn, synchronous): length, CR flag, enables and output valid cleared; no sweep.
module serial_line_assembler (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [sla_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sla_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_rx_byte,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_result_kind,
    output logic [7:0]                       m_line_byte,
    output logic                             m_last_of_line
);
    import sla_pkg::*;

    sla_cmd_t    cmd;
    sla_status_t status;

    sla_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sla_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_rx_byte      (s_rx_byte),
        .cmd            (cmd),
        .status         (status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_line_byte    (m_line_byte),
        .m_last_of_line (m_last_of_line)
    );

endmodule

// ===== hw/rtl/sla_ctrl.sv =====
// Controller FSM for the serial line assembler: input handshake and line readout sequencing.
// Depends on sla_pkg.
module sla_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sla_pkg::sla_status_t status,
    output sla_pkg::sla_cmd_t    cmd
);
    import sla_pkg::*;

    sla_state_t state_reg;
    sla_state_t state_next;
    logic       accept;

    assign s_ready = (state_reg == ST_IDLE) && status.out_free;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && !status.len_zero && status.line_en &&
                    (status.is_cr || (status.is_lf && !status.cr_seen))) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free && status.last_idx) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (status.is_lf && status.cr_seen) begin
                        cmd.clear_cr = 1'b1;
                    end else if (status.is_lf || status.is_cr) begin
                        cmd.set_cr   = status.is_cr;
                        cmd.clear_cr = status.is_lf;
                        if (!status.line_en) begin
                            cmd.clear_len = 1'b1;
                        end else if (status.len_zero) begin
                            cmd.load_empty = 1'b1;
                        end else begin
                            cmd.start_read = 1'b1;
                        end
                    end else begin
                        cmd.clear_cr = 1'b1;
                        if (status.len_full) begin
                            cmd.clear_len  = 1'b1;
                            cmd.load_error = status.err_en;
                        end else begin
                            cmd.store_byte = 1'b1;
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.load_byte = 1'b1;
                    // length stays valid until the last byte goes out
                    cmd.clear_len = status.last_idx;
                    cmd.advance   = !status.last_idx;
                end
            end
            default: cmd = '0;
        endcase
    end

endmodule

// ===== hw/rtl/sla_datapath.sv =====
// Datapath for the serial line assembler: line store, length, CR flag, enables, output word.
// Depends on sla_pkg.
module sla_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [sla_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sla_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [7:0]                          s_rx_byte,
    input  sla_pkg::sla_cmd_t                   cmd,
    output sla_pkg::sla_status_t                status,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_result_kind,
    output logic [7:0]                          m_line_byte,
    output logic                                m_last_of_line
);
    import sla_pkg::*;

    logic [7:0]        line_mem [STORE_DEPTH];
    logic [7:0]        rd_data_reg;

    logic [LEN_W-1:0]  line_length_reg, line_length_next;
    logic              cr_seen_reg, cr_seen_next;
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;
    logic              line_en_reg, err_en_reg;

    logic              m_valid_reg, m_valid_next;
    logic [1:0]        kind_reg;
    logic [7:0]        byte_reg;
    logic              last_reg;
    logic              load_any;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_en_reg <= 1'b0;
            err_en_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_LINE_EN: line_en_reg <= cfg_wdata[0];
                REG_ERR_EN:  err_en_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        line_length_next = line_length_reg;
        if (cmd.clear_len) begin
            line_length_next = '0;
        end else if (cmd.store_byte) begin
            line_length_next = line_length_reg + LEN_W'(1);
        end

        cr_seen_next = cr_seen_reg;
        if (cmd.set_cr) begin
            cr_seen_next = 1'b1;
        end else if (cmd.clear_cr) begin
            cr_seen_next = 1'b0;
        end

        rd_idx_next = rd_idx_reg;
        if (cmd.start_read) begin
            rd_idx_next = '0;
        end else if (cmd.advance) begin
            rd_idx_next = rd_idx_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_length_reg <= '0;
            cr_seen_reg     <= 1'b0;
            rd_idx_reg      <= '0;
        end else begin
            line_length_reg <= line_length_next;
            cr_seen_reg     <= cr_seen_next;
            rd_idx_reg      <= rd_idx_next;
        end
    end

    // rd_data_reg holds the entry at rd_idx_reg as read before the write at the same edge
    always_ff @(posedge aclk) begin
        if (cmd.store_byte) begin
            line_mem[line_length_reg[ADDR_W-1:0]] <= s_rx_byte;
        end
        rd_data_reg <= line_mem[rd_idx_next];
    end

    // output word
    assign load_any = cmd.load_byte || cmd.load_empty || cmd.load_error;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_any) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_byte) begin
            kind_reg <= KIND_BYTE;
            byte_reg <= rd_data_reg;
            last_reg <= status.last_idx;
        end else if (cmd.load_empty) begin
            kind_reg <= KIND_EMPTY;
            byte_reg <= CH_NUL;
            last_reg <= 1'b1;
        end else if (cmd.load_error) begin
            kind_reg <= KIND_TOO_LONG;
            byte_reg <= CH_NUL;
            last_reg <= 1'b1;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_kind  = kind_reg;
    assign m_line_byte    = byte_reg;
    assign m_last_of_line = last_reg;

    always_comb begin
        status          = '0;
        status.is_lf    = (s_rx_byte == CH_LF);
        status.is_cr    = (s_rx_byte == CH_CR);
        status.cr_seen  = cr_seen_reg;
        status.len_zero = (line_length_reg == '0);
        status.len_full = (line_length_reg == LEN_W'(STORE_DEPTH));
        status.last_idx = ((LEN_W'(rd_idx_reg) + LEN_W'(1)) == line_length_reg);
        status.out_free = !m_valid_reg || m_ready;
        status.line_en  = line_en_reg;
        status.err_en   = err_en_reg;
    end

endmodule
